@@ rtl/pce_pkg.sv @@
// Shared types, widths and constants for the polyline coordinate encoder.
// Depends on nothing; every other file of the block imports it.
package pce_pkg;

	// Input format and scaling.
	localparam int FRAC_BITS    = 22;
	localparam int MAX_DECIMALS = 7;
	localparam int DP_W         = 3;
	localparam int LAT_W        = 30;
	localparam int LON_W        = 31;
	localparam int POW_W        = 24;
	localparam int PROD_W       = LON_W + POW_W;
	localparam int QUO_W        = PROD_W - FRAC_BITS;
	localparam int SCALE_W      = 32;
	localparam int DIFF_W       = SCALE_W + 1;
	localparam int CODE_W       = DIFF_W + 1;

	// Character output.
	localparam int CHAR_W    = 7;
	localparam int CHUNK_W   = 5;
	localparam int CHAR_BIAS = 63;
	localparam int CONT_BIT  = 'h20;

	// Queue between the front and the back.
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;
	localparam int LVL_W   = 3;

	// Configuration port.
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;
	localparam logic REG_DECIMALS = 1'b0;   // register index taken from paddr[2]
	localparam logic [DP_W-1:0] DP_RESET = 3'd5;

	typedef logic [CODE_W-1:0] code_t;

	// One queued point: the folded codes of both coordinates.
	typedef struct packed {
		code_t lat_code;
		code_t lon_code;
	} pce_entry_t;

	typedef struct packed {
		logic       valid;
		pce_entry_t entry;
	} pce_push_t;

	typedef struct packed {
		logic [LVL_W-1:0] level;
		logic             empty;
	} pce_q_stat_t;

	// Powers of ten for the decimal places setting.
	function automatic logic [POW_W-1:0] pow10(input logic [DP_W-1:0] dp);
		logic [POW_W-1:0] p;
		case (dp)
			3'd0: p = 24'd1;
			3'd1: p = 24'd10;
			3'd2: p = 24'd100;
			3'd3: p = 24'd1000;
			3'd4: p = 24'd10000;
			3'd5: p = 24'd100000;
			3'd6: p = 24'd1000000;
			3'd7: p = 24'd10000000;
			default: p = 24'd1;
		endcase
		return p;
	endfunction

endpackage

@@ rtl/pce_in_if.sv @@
// Input channel of the encoder: one coordinate pair per request.
// Depends on pce_pkg for the field widths.
interface pce_in_if;
	import pce_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [LAT_W-1:0] latitude;
	logic signed [LON_W-1:0] longitude;
	logic                    first_point;

	modport source (output valid, latitude, longitude, first_point, input ready);
	modport sink (input valid, latitude, longitude, first_point, output ready);
endinterface

@@ rtl/pce_out_if.sv @@
// Output channel of the encoder: one character per request.
// Depends on pce_pkg for the field widths.
interface pce_out_if;
	import pce_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] out_char;
	logic              last_char;

	modport source (output valid, out_char, last_char, input ready);
	modport sink (input valid, out_char, last_char, output ready);
endinterface

@@ rtl/pce_front.sv @@
// Front part: accepts points, scales them, forms deltas and folded codes.
// Depends on pce_pkg and pce_in_if; pushes entries into pce_queue.
module pce_front (
	input  logic                    clk,
	input  logic                    arst_n,
	pce_in_if.sink                  points,
	input  logic [pce_pkg::DP_W-1:0] decimal_places,
	input  pce_pkg::pce_q_stat_t    q_stat,
	output pce_pkg::pce_push_t      push
);
	import pce_pkg::*;

	// Truncated quotient to signed 32 bits with saturation at both bounds.
	function automatic logic signed [SCALE_W-1:0] saturate(
		input logic [QUO_W-1:0] q,
		input logic             neg
	);
		logic signed [SCALE_W-1:0] r;
		if (neg) begin
			if (q > QUO_W'(33'h0_8000_0000)) r = {1'b1, {(SCALE_W-1){1'b0}}};
			else r = -q[SCALE_W-1:0];
		end else begin
			if (q > QUO_W'(33'h0_7fff_ffff)) r = {1'b0, {(SCALE_W-1){1'b1}}};
			else r = q[SCALE_W-1:0];
		end
		return r;
	endfunction

	logic [DP_W-1:0]   dp_eff;
	logic [POW_W-1:0]  pow_c;
	logic [LAT_W-1:0]  mag_lat;
	logic [LON_W-1:0]  mag_lon;
	logic              accept;

	logic              valid_s1;
	logic [PROD_W-1:0] prod_lat_s1;
	logic [PROD_W-1:0] prod_lon_s1;
	logic              neg_lat_s1;
	logic              neg_lon_s1;
	logic              first_s1;

	logic signed [SCALE_W-1:0] lat_scaled;
	logic signed [SCALE_W-1:0] lon_scaled;
	logic signed [SCALE_W-1:0] prev_lat_q;
	logic signed [SCALE_W-1:0] prev_lon_q;

	logic                      valid_s2;
	logic signed [SCALE_W-1:0] lat_s2;
	logic signed [SCALE_W-1:0] lon_s2;
	logic signed [SCALE_W-1:0] base_lat_s2;
	logic signed [SCALE_W-1:0] base_lon_s2;

	logic signed [DIFF_W-1:0] d_lat;
	logic signed [DIFF_W-1:0] d_lon;

	// A request is taken only when the queue has room for everything in flight.
	assign points.ready = (LVL_W'(q_stat.level + LVL_W'(valid_s1) + LVL_W'(valid_s2))
		< LVL_W'(Q_DEPTH));
	assign accept = points.valid && points.ready;

	// Magnitudes and the power of ten feed the two multipliers.
	assign dp_eff  = (decimal_places > DP_W'(MAX_DECIMALS)) ? DP_W'(MAX_DECIMALS)
		: decimal_places;
	assign pow_c   = pow10(dp_eff);
	assign mag_lat = points.latitude[LAT_W-1] ? LAT_W'(~points.latitude + 1'b1)
		: LAT_W'(points.latitude);
	assign mag_lon = points.longitude[LON_W-1] ? LON_W'(~points.longitude + 1'b1)
		: LON_W'(points.longitude);

	// Stage 1: products of magnitude and power of ten.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_lat_s1 <= PROD_W'(mag_lat) * PROD_W'(pow_c);
			prod_lon_s1 <= PROD_W'(mag_lon) * PROD_W'(pow_c);
			neg_lat_s1  <= points.latitude[LAT_W-1];
			neg_lon_s1  <= points.longitude[LON_W-1];
			first_s1    <= points.first_point;
		end
	end

	// Drop the fraction bits, restore the sign and saturate.
	assign lat_scaled = saturate(prod_lat_s1[PROD_W-1:FRAC_BITS], neg_lat_s1);
	assign lon_scaled = saturate(prod_lon_s1[PROD_W-1:FRAC_BITS], neg_lon_s1);

	// Stage 2: scaled values, the base to subtract, and the previous point.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2   <= 1'b0;
			prev_lat_q <= '0;
			prev_lon_q <= '0;
		end else begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				prev_lat_q <= lat_scaled;
				prev_lon_q <= lon_scaled;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			lat_s2      <= lat_scaled;
			lon_s2      <= lon_scaled;
			base_lat_s2 <= first_s1 ? '0 : prev_lat_q;
			base_lon_s2 <= first_s1 ? '0 : prev_lon_q;
		end
	end

	// Delta in 33 bits, then doubled and inverted when negative.
	assign d_lat = DIFF_W'(lat_s2) - DIFF_W'(base_lat_s2);
	assign d_lon = DIFF_W'(lon_s2) - DIFF_W'(base_lon_s2);

	assign push.valid          = valid_s2;
	assign push.entry.lat_code = {d_lat, 1'b0} ^ {CODE_W{d_lat[DIFF_W-1]}};
	assign push.entry.lon_code = {d_lon, 1'b0} ^ {CODE_W{d_lon[DIFF_W-1]}};

endmodule

@@ rtl/pce_queue.sv @@
// Short queue of folded points between the front and the back.
// Depends on pce_pkg for the entry type and depth.
module pce_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pce_pkg::pce_push_t   push,
	input  logic                 pop,
	output pce_pkg::pce_entry_t  rdata,
	output pce_pkg::pce_q_stat_t stat
);
	import pce_pkg::*;

	pce_entry_t       mem_q [Q_DEPTH];
	logic [Q_AW-1:0]  wr_ptr_q;
	logic [Q_AW-1:0]  rd_ptr_q;
	logic [LVL_W-1:0] level_q;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push.valid) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push.valid, pop})
				2'b10: level_q <= level_q + 1'b1;
				2'b01: level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push.valid) mem_q[wr_ptr_q] <= push.entry;
	end

	assign rdata      = mem_q[rd_ptr_q];
	assign stat.level = level_q;
	assign stat.empty = (level_q == '0);

endmodule

@@ rtl/pce_back.sv @@
// Back part: splits the folded codes into 5-bit chunks, one character per cycle while chars.ready is high.
// Depends on pce_pkg and pce_out_if; pops entries from pce_queue.
module pce_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pce_pkg::pce_entry_t  rdata,
	input  pce_pkg::pce_q_stat_t q_stat,
	output logic                 pop,
	pce_out_if.source            chars
);
	import pce_pkg::*;

	logic              busy_q;
	logic              lon_phase_q;
	code_t             cur_q;
	code_t             lon_code_q;
	logic              o_valid_q;
	logic [CHAR_W-1:0] o_char_q;
	logic              o_last_q;

	logic              adv;
	logic              step;
	logic              more;
	logic [CHAR_W-1:0] char_c;

	// The output register moves when it is empty or being taken.
	assign adv  = !o_valid_q || chars.ready;
	assign step = busy_q && adv;
	assign pop  = !busy_q && !q_stat.empty;
	assign more = |cur_q[CODE_W-1:CHUNK_W];

	// Chunk character: continuation flag when more chunks follow, plus the bias.
	assign char_c = more
		? CHAR_W'(CHAR_W'(CONT_BIT) | CHAR_W'(cur_q[CHUNK_W-1:0])) + CHAR_W'(CHAR_BIAS)
		: CHAR_W'(cur_q[CHUNK_W-1:0]) + CHAR_W'(CHAR_BIAS);

	// Chunk sequencer: latitude code first, then longitude.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			lon_phase_q <= 1'b0;
		end else if (pop) begin
			busy_q      <= 1'b1;
			lon_phase_q <= 1'b0;
		end else if (step && !more) begin
			if (lon_phase_q) busy_q <= 1'b0;
			lon_phase_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q      <= rdata.lat_code;
			lon_code_q <= rdata.lon_code;
		end else if (step) begin
			if (more) cur_q <= cur_q >> CHUNK_W;
			else cur_q <= lon_code_q;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (adv) begin
			o_valid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			o_char_q <= char_c;
			o_last_q <= lon_phase_q && !more;
		end
	end

	assign chars.valid     = o_valid_q;
	assign chars.out_char  = o_char_q;
	assign chars.last_char = o_last_q;

endmodule

@@ rtl/polyline_coordinate_encoder.sv @@
// Polyline coordinate encoder, top level: register port, front, queue and back.
// Path: front stages 1 and 2, the queue, the chunk sequencer, then the output register.
// Throughput: one character per cycle within a point while chars.ready is high; a point
// of 2 to 14 characters holds the chunk sequencer until its last character is stepped out.
// Reset: arst_n clears control state, the previous point to zero and decimal_places to 5.
module polyline_coordinate_encoder (
	input  logic                       clk,
	input  logic                       arst_n,
	pce_in_if.sink                     points,
	pce_out_if.source                  chars,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pce_pkg::ADDR_W-1:0] paddr,
	input  logic [pce_pkg::DATA_W-1:0] pwdata,
	output logic [pce_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import pce_pkg::*;

	logic [DP_W-1:0] decimal_places_q;
	pce_push_t       push;
	pce_entry_t      q_rdata;
	pce_q_stat_t     q_stat;
	logic            pop;

	// Configuration register.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decimal_places_q <= DP_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_DECIMALS)) begin
			decimal_places_q <= pwdata[DP_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_DECIMALS) ? DATA_W'(decimal_places_q) : '0;

	// Datapath.
	pce_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.points         (points),
		.decimal_places (decimal_places_q),
		.q_stat         (q_stat),
		.push           (push)
	);

	pce_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	pce_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.rdata  (q_rdata),
		.q_stat (q_stat),
		.pop    (pop),
		.chars  (chars)
	);

	// The credit check must keep the queue from overflowing.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> (q_stat.level < LVL_W'(Q_DEPTH)) || pop)
		else $error("queue push while full");

	// The back must never pop an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("queue pop while empty");

	// The fill level stays within the queue depth.
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.level <= LVL_W'(Q_DEPTH))
		else $error("queue level out of range");

endmodule
